@@ hdl/esq_pkg.sv @@
// Shared constants and state types for the euclidean rhythm sequencer.
package esq_pkg;

  localparam int MAX_LENGTH_DEF = 256;
  localparam int CFG_W          = 9;
  localparam int IDX_W          = 8;
  localparam int TDATA_W        = 8;

  localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 8'd0;
  localparam logic [IDX_W-1:0] REG_PULSE_COUNT    = 8'd1;

  localparam logic [CFG_W-1:0] PATTERN_LENGTH_RST = 9'd8;
  localparam logic [CFG_W-1:0] PULSE_COUNT_RST    = 9'd0;

  typedef enum logic [3:0] {
    B_INIT,
    B_SEED,
    B_CHECK,
    B_CPA,
    B_CPB,
    B_FINP,
    B_FINQ,
    B_DRAIN,
    B_DONE
  } build_state_t;

  typedef enum logic [1:0] {
    P_IDLE,
    P_MOD,
    P_READ,
    P_CAPT
  } play_state_t;

endpackage

@@ hdl/esq_build.sv @@
// Pattern builder: group strings kept in a slot memory, rewritten level by level.
module esq_build #(
  parameter int MaxLength = esq_pkg::MAX_LENGTH_DEF,
  localparam int LW = $clog2(MaxLength + 1),
  localparam int PW = $clog2(MaxLength)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic [LW-1:0] len,
  input  logic [LW-1:0] pulses,
  output logic          busy,
  output logic          pat_we,
  output logic [PW-1:0] pat_waddr,
  output logic          pat_wdata
);

  // three slots used, addressed as {slot, offset}
  logic slot_mem [4 * (2 ** PW)];

  esq_pkg::build_state_t state, state_next;

  logic [LW-1:0] p, q, lp, lq, cnt, dpos, reps;
  logic [1:0]    sp, sq, sf;
  logic          wv, wpat;
  logic [1:0]    wslot;
  logic [PW-1:0] woff;
  logic          rdata;

  logic [1:0]    rd_slot;
  logic          copying, fin_phase, last_a, last_b;
  logic          seed_we, seed_data;
  logic [1:0]    seed_slot;
  logic          mem_we, mem_wdata;
  logic [1:0]    mem_wslot;
  logic [PW-1:0] mem_woff;

  assign last_a = (cnt == lp - LW'(1));
  assign last_b = (cnt == lq - LW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      esq_pkg::B_INIT:  state_next = esq_pkg::B_SEED;
      esq_pkg::B_SEED:  state_next = esq_pkg::B_CHECK;
      esq_pkg::B_CHECK: begin
        if (p == '0)
          state_next = esq_pkg::B_FINQ;
        else if (q < LW'(2))
          state_next = esq_pkg::B_FINP;
        else
          state_next = esq_pkg::B_CPA;
      end
      esq_pkg::B_CPA:   if (last_a) state_next = esq_pkg::B_CPB;
      esq_pkg::B_CPB:   if (last_b) state_next = esq_pkg::B_CHECK;
      esq_pkg::B_FINP: begin
        if (last_a && reps == LW'(1))
          state_next = (q == '0) ? esq_pkg::B_DRAIN : esq_pkg::B_FINQ;
      end
      esq_pkg::B_FINQ:  if (last_b && reps == LW'(1)) state_next = esq_pkg::B_DRAIN;
      esq_pkg::B_DRAIN: state_next = esq_pkg::B_DONE;
      esq_pkg::B_DONE:  state_next = esq_pkg::B_DONE;
      default:          state_next = esq_pkg::B_INIT;
    endcase
    if (restart)
      state_next = esq_pkg::B_INIT;
  end

  always_comb begin
    rd_slot   = sp;
    copying   = 1'b0;
    fin_phase = 1'b0;
    seed_we   = 1'b0;
    seed_slot = 2'd0;
    seed_data = 1'b1;
    busy      = 1'b1;
    unique case (state)
      esq_pkg::B_INIT: begin
        seed_we = 1'b1;
      end
      esq_pkg::B_SEED: begin
        seed_we   = 1'b1;
        seed_slot = 2'd1;
        seed_data = 1'b0;
      end
      esq_pkg::B_CPA:  copying = 1'b1;
      esq_pkg::B_CPB: begin
        copying = 1'b1;
        rd_slot = sq;
      end
      esq_pkg::B_FINP: begin
        copying   = 1'b1;
        fin_phase = 1'b1;
      end
      esq_pkg::B_FINQ: begin
        copying   = 1'b1;
        fin_phase = 1'b1;
        rd_slot   = sq;
      end
      esq_pkg::B_DONE: busy = 1'b0;
      default: ;
    endcase
  end

  assign sf = 2'd3 - sp - sq;

  // slot memory: one write port, one registered read port
  assign mem_we    = seed_we | (wv & ~wpat);
  assign mem_wslot = seed_we ? seed_slot : wslot;
  assign mem_woff  = seed_we ? '0 : woff;
  assign mem_wdata = seed_we ? seed_data : rdata;

  always_ff @(posedge clk) begin
    if (mem_we)
      slot_mem[{mem_wslot, mem_woff}] <= mem_wdata;
    rdata <= slot_mem[{rd_slot, cnt[PW-1:0]}];
  end

  assign pat_we    = wv & wpat;
  assign pat_waddr = woff;
  assign pat_wdata = rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esq_pkg::B_INIT;
      wv    <= 1'b0;
    end else begin
      state <= state_next;
      wv    <= copying & ~restart;
    end
  end

  always_ff @(posedge clk) begin
    wpat  <= fin_phase;
    wslot <= sf;
    woff  <= dpos[PW-1:0];
    unique case (state)
      esq_pkg::B_INIT: begin
        p  <= pulses;
        q  <= len - pulses;
        lp <= LW'(1);
        lq <= LW'(1);
        sp <= 2'd0;
        sq <= 2'd1;
      end
      esq_pkg::B_CHECK: begin
        cnt  <= '0;
        dpos <= '0;
        reps <= (p == '0) ? q : p;
      end
      esq_pkg::B_CPA: begin
        dpos <= dpos + LW'(1);
        cnt  <= last_a ? '0 : cnt + LW'(1);
      end
      esq_pkg::B_CPB: begin
        dpos <= dpos + LW'(1);
        cnt  <= cnt + LW'(1);
        if (last_b) begin
          // pair the groups: new first group is P followed by Q
          sp <= sf;
          lp <= lp + lq;
          if (p > q) begin
            sq <= sp;
            lq <= lp;
            p  <= q;
            q  <= p - q;
          end else begin
            q  <= q - p;
          end
        end
      end
      esq_pkg::B_FINP: begin
        dpos <= dpos + LW'(1);
        cnt  <= last_a ? '0 : cnt + LW'(1);
        if (last_a)
          reps <= (reps == LW'(1)) ? q : reps - LW'(1);
      end
      esq_pkg::B_FINQ: begin
        dpos <= dpos + LW'(1);
        cnt  <= last_b ? '0 : cnt + LW'(1);
        if (last_b)
          reps <= reps - LW'(1);
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/esq_player.sv @@
// Step player: pattern memory, step position, wrap unit and result register.
module esq_player #(
  parameter int MaxLength = esq_pkg::MAX_LENGTH_DEF,
  localparam int LW = $clog2(MaxLength + 1),
  localparam int PW = $clog2(MaxLength),
  localparam int CW = $clog2(LW)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [LW-1:0] len,
  input  logic          built,
  input  logic          pat_we,
  input  logic [PW-1:0] pat_waddr,
  input  logic          pat_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          trigger,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          gate
);

  logic pat_mem [2 ** PW];

  esq_pkg::play_state_t state, state_next;

  logic [PW-1:0] pos;
  logic          started;
  logic [LW-1:0] num, rem;
  logic [CW-1:0] bitcnt;
  logic          rdata;

  logic          accept, out_free, take_trig, wraps;
  logic [LW-1:0] pos_inc;
  logic [LW:0]   rem_shift, rem_sub;
  logic          rem_ge;

  assign out_free  = ~out_valid | out_ready;
  assign accept    = in_valid & in_ready;
  assign take_trig = accept & trigger;
  assign pos_inc   = LW'(pos) + LW'(1);
  assign wraps     = started & (pos_inc >= len);

  // restoring remainder, one dividend bit a cycle
  assign rem_shift = {rem, num[LW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, len});
  assign rem_sub   = rem_shift - {1'b0, len};

  always_comb begin
    state_next = state;
    unique case (state)
      esq_pkg::P_IDLE: if (take_trig) state_next = wraps ? esq_pkg::P_MOD : esq_pkg::P_READ;
      esq_pkg::P_MOD:  if (bitcnt == '0) state_next = esq_pkg::P_READ;
      esq_pkg::P_READ: state_next = esq_pkg::P_CAPT;
      esq_pkg::P_CAPT: state_next = esq_pkg::P_IDLE;
      default:         state_next = esq_pkg::P_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      esq_pkg::P_IDLE: in_ready = built & out_free;
      default:         in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pat_we)
      pat_mem[pat_waddr] <= pat_wdata;
    rdata <= pat_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= esq_pkg::P_IDLE;
      started   <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take_trig) begin
        started <= 1'b1;
        if (!started)
          pos <= '0;
        else if (!wraps)
          pos <= pos_inc[PW-1:0];
      end
      if (state == esq_pkg::P_MOD && bitcnt == '0)
        pos <= rem_ge ? rem_sub[PW-1:0] : rem_shift[PW-1:0];
      if ((accept && !trigger) || state == esq_pkg::P_CAPT)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !trigger)
      gate <= 1'b0;
    else if (state == esq_pkg::P_CAPT)
      gate <= rdata;
    if (take_trig) begin
      num    <= pos_inc;
      rem    <= '0;
      bitcnt <= CW'(LW - 1);
    end else if (state == esq_pkg::P_MOD) begin
      num    <= num << 1;
      rem    <= rem_ge ? rem_sub[LW-1:0] : rem_shift[LW-1:0];
      bitcnt <= bitcnt - CW'(1);
    end
  end

endmodule

@@ hdl/euclidean_rhythm_sequencer_core.sv @@
// Top level of the euclidean rhythm sequencer: config registers, builder, player.
//
// Use:
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes pattern_length
//   (index 0) and pulse_count (index 1); cfg_ready is always high. A write to
//   a known register restarts the pattern build; unknown indexes are ignored.
//   s_axis carries one tick per transfer (tdata bit 0 = trigger). m_axis
//   returns one gate bit per tick (tdata bit 0 = gate), in order.
// Build: after reset or a config write the builder rewrites group strings in
//   its slot memory, one bit per cycle, then copies the final pattern into
//   the pattern memory; s_tready stays low until it finishes. Step position
//   is kept.
// Ticks: an untriggered tick has its result in the cycle after the
//   transfer. A tick with trigger steps through position update, pattern
//   memory read and result load; no new tick is taken until it is done.
//   When the step wraps (next position reaches the length, or has
//   run past a shortened length), a bit-serial remainder runs first.
// Reset: length 8, no pulses, position before first step; a build starts.
// Stall: the result sits in an output register; s_tready drops until the
//   receiver takes it.
module euclidean_rhythm_sequencer_core #(
  parameter int MaxLength = esq_pkg::MAX_LENGTH_DEF,
  localparam int LW = $clog2(MaxLength + 1),
  localparam int PW = $clog2(MaxLength),
  localparam int EW = (LW > esq_pkg::CFG_W) ? LW : esq_pkg::CFG_W
) (
  input  logic                        clk,
  input  logic                        rst,
  // config write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [esq_pkg::IDX_W-1:0]   cfg_index,
  input  logic [esq_pkg::CFG_W-1:0]   cfg_data,
  // tick input
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [esq_pkg::TDATA_W-1:0] s_tdata,   // [0] trigger, [7:1] zero
  // gate output
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [esq_pkg::TDATA_W-1:0] m_tdata    // [0] gate, [7:1] zero
);

  logic [esq_pkg::CFG_W-1:0] len_cfg, pulse_cfg;
  logic                      cfg_xfer, restart;
  logic [EW-1:0]             len_ext, pulse_ext;
  logic [LW-1:0]             eff_len, eff_pulses;
  logic                      busy;
  logic                      pat_we, pat_wdata, gate;
  logic [PW-1:0]             pat_waddr;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;
  assign restart   = cfg_xfer & ((cfg_index == esq_pkg::REG_PATTERN_LENGTH) ||
                                 (cfg_index == esq_pkg::REG_PULSE_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg   <= esq_pkg::PATTERN_LENGTH_RST;
      pulse_cfg <= esq_pkg::PULSE_COUNT_RST;
    end else if (cfg_xfer) begin
      if (cfg_index == esq_pkg::REG_PATTERN_LENGTH)
        len_cfg <= cfg_data;
      else if (cfg_index == esq_pkg::REG_PULSE_COUNT)
        pulse_cfg <= cfg_data;
    end
  end

  // length clamped to 1..MaxLength, pulses saturated at the length
  always_comb begin
    len_ext   = EW'(len_cfg);
    pulse_ext = EW'(pulse_cfg);
    if (len_ext == '0)
      eff_len = LW'(1);
    else if (len_ext > EW'(MaxLength))
      eff_len = LW'(MaxLength);
    else
      eff_len = len_ext[LW-1:0];
    if (pulse_ext > EW'(eff_len))
      eff_pulses = eff_len;
    else
      eff_pulses = pulse_ext[LW-1:0];
  end

  esq_build #(.MaxLength(MaxLength)) u_build (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .len       (eff_len),
    .pulses    (eff_pulses),
    .busy      (busy),
    .pat_we    (pat_we),
    .pat_waddr (pat_waddr),
    .pat_wdata (pat_wdata)
  );

  esq_player #(.MaxLength(MaxLength)) u_player (
    .clk       (clk),
    .rst       (rst),
    .len       (eff_len),
    .built     (~busy),
    .pat_we    (pat_we),
    .pat_waddr (pat_waddr),
    .pat_wdata (pat_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .trigger   (s_tdata[0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .gate      (gate)
  );

  assign m_tdata = {{(esq_pkg::TDATA_W-1){1'b0}}, gate};

`ifndef ASSERT_OFF
  // no tick taken while the pattern is being rebuilt
  a_ready_built: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !busy)
    else $error("tick accepted during pattern build");

  // a tick is only taken when the result register can take its result
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
    else $error("tick accepted with result stalled");

  // the pattern memory is only written while building
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    pat_we |-> busy)
    else $error("pattern write outside build");
`endif

endmodule
